### src/alcr_pkg.sv
// Package for the audio loop capture/replay block: sizes, register indexes and
// arithmetic constants. No dependencies.
`default_nettype none
package alcr_pkg;

  localparam int LOOP_DEPTH  = 262144;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W = $clog2(LOOP_DEPTH);
  localparam int POS_W  = ADDR_W + 1;
  localparam int LEN_W  = 19;
  localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int GAIN_W = 16;
  localparam int FRAC_BITS = GAIN_W - 1;

  // signed sample times signed gain (gain zero-extended by one bit)
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RES_W  = SUM_W - FRAC_BITS;

  localparam logic [POS_W-1:0]  DEPTH_POS  = POS_W'(LOOP_DEPTH);
  localparam logic [GAIN_W-1:0] UNITY_GAIN = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

  localparam logic [LEN_W-1:0] LOOP_LENGTH_RST = LEN_W'(24000);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_PLAY = 1'd1;

endpackage
`default_nettype wire

### src/audio_loop_capture_replay.sv
// Audio loop capture and replay: records samples into a loop memory and
// crossfades dry input with a forward or reverse replay. Uses alcr_pkg.
//
//   port group | dir | contents
//   in_*       | in  | tdata = {mix_gain, sample_in}, tuser = restart
//   out_*      | out | tdata = sample_out, tuser = looping
//   cfg_*      | in  | write enable, register index, data (19 bits)
//
// One item per cycle while the output is not stalled by out_tready. Three
// register stages (memory read, product register, sum/saturate output
// register) carry an item from the input transfer to out_tvalid and out_tdata.
// The loop memory has one write and one read port; both are used in the
// transfer cycle. A read of the entry written in the same cycle takes the
// dry sample instead. Synchronous active-low reset clears positions and
// pipeline valids; the memory is not cleared. Ready is combinational through
// the stages: in_tready drops only when all three stages hold items and
// out_tready is low.
`default_nettype none
module audio_loop_capture_replay (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [31:0]                     in_tdata,   // sample_in[15:0], mix_gain[31:16]
  input  wire logic                            in_tuser,   // restart
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [15:0]                          out_tdata,  // sample_out[15:0]
  output logic                                 out_tuser,  // looping
  input  wire logic                            cfg_we,
  input  wire logic [alcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [alcr_pkg::LEN_W-1:0]      cfg_data
);

  localparam int SB  = alcr_pkg::SAMPLE_BITS;
  localparam int GW  = alcr_pkg::GAIN_W;
  localparam int AW  = alcr_pkg::ADDR_W;
  localparam int PW  = alcr_pkg::POS_W;
  localparam int CW  = alcr_pkg::CMP_W;
  localparam int PRW = alcr_pkg::PROD_W;
  localparam int SW  = alcr_pkg::SUM_W;
  localparam int RW  = alcr_pkg::RES_W;

  localparam logic signed [RW-1:0] SAT_MAX = RW'((1 << (SB - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_MIN = -SAT_MAX - RW'(1);

  // configuration
  logic [alcr_pkg::LEN_W-1:0] loop_length_r;
  logic                       reverse_play_r;

  // loop state
  logic [PW-1:0] wr_pos_r, wr_pos_nxt;
  logic [PW-1:0] rd_pos_r, rd_pos_nxt;
  logic          recording_r, recording_nxt;

  logic [SB-1:0] loop_mem [alcr_pkg::LOOP_DEPTH];
  logic [SB-1:0] rd_data_r;

  // stage 1: memory read in flight
  logic          v1_r;
  logic [SB-1:0] dry1_r;
  logic [GW-1:0] gain1_r;
  logic          fwd1_r, loop1_r;

  // stage 2: products
  logic                  v2_r;
  logic signed [PRW-1:0] pdry2_r, pwet2_r;
  logic                  loop2_r;

  // stage 3: output
  logic          out_valid_r;
  logic [SB-1:0] out_data_r;
  logic          out_loop_r;

  logic s1_free, s2_free, s3_free, accept, adv1, adv2;

  assign s3_free   = !out_valid_r || out_tready;
  assign s2_free   = !v2_r || s3_free;
  assign s1_free   = !v1_r || s2_free;
  assign adv2      = v2_r && s3_free;
  assign adv1      = v1_r && s2_free;
  assign in_tready = s1_free;
  assign accept    = in_tvalid && s1_free;

  logic [SB-1:0] in_sample;
  logic [GW-1:0] in_gain;
  assign in_sample = in_tdata[SB-1:0];
  assign in_gain   = in_tdata[SB+GW-1:SB];

  // window bounds
  logic [CW-1:0] len_ext;
  logic [PW-1:0] win_len, win_start, win_end;

  always_comb begin
    len_ext = CW'(loop_length_r);
    if (len_ext == '0)
      win_len = PW'(1);
    else if (len_ext > CW'(alcr_pkg::DEPTH_POS))
      win_len = alcr_pkg::DEPTH_POS;
    else
      win_len = PW'(len_ext);
    win_start = reverse_play_r ? alcr_pkg::DEPTH_POS - win_len : '0;
    win_end   = reverse_play_r ? alcr_pkg::DEPTH_POS : win_len;
  end

  // position update for the item being transferred
  logic [PW-1:0] wp0, rp0, rp2, rd_mirror;
  logic          rec0, wr_en, loop_now, fwd_now;
  logic [AW-1:0] wr_addr, rd_addr;

  always_comb begin
    wp0  = in_tuser ? '0 : wr_pos_r;
    rp0  = in_tuser ? win_start : rd_pos_r;
    rec0 = in_tuser ? 1'b1 : recording_r;

    wr_en         = accept && rec0 && (wp0 < alcr_pkg::DEPTH_POS);
    wr_addr       = wp0[AW-1:0];
    wr_pos_nxt    = wr_pos_r;
    recording_nxt = recording_r;
    rd_pos_nxt    = rd_pos_r;

    if (rec0 && wp0 < alcr_pkg::DEPTH_POS)
      wr_pos_nxt = wp0 + PW'(1);
    else
      wr_pos_nxt = wp0;
    if (rec0 && wp0 >= alcr_pkg::DEPTH_POS)
      recording_nxt = 1'b0;
    else
      recording_nxt = rec0;

    loop_now  = wr_pos_nxt >= win_len;
    rp2       = (rp0 < win_start || rp0 >= win_end) ? win_start : rp0;
    rd_mirror = alcr_pkg::DEPTH_POS - PW'(1) - rp2;
    rd_addr   = reverse_play_r ? rd_mirror[AW-1:0] : rp2[AW-1:0];
    fwd_now   = wr_en && (rd_addr == wr_addr);
    rd_pos_nxt = loop_now ? rp2 + PW'(1) : rp0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_length_r  <= alcr_pkg::LOOP_LENGTH_RST;
      reverse_play_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        alcr_pkg::REG_LOOP_LENGTH:  loop_length_r  <= cfg_data;
        alcr_pkg::REG_REVERSE_PLAY: reverse_play_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      recording_r <= 1'b1;
    end else if (accept) begin
      wr_pos_r    <= wr_pos_nxt;
      rd_pos_r    <= rd_pos_nxt;
      recording_r <= recording_nxt;
    end
  end

  // loop memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en)
      loop_mem[wr_addr] <= in_sample;
    if (accept)
      rd_data_r <= loop_mem[rd_addr];
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n)
      v1_r <= 1'b0;
    else if (s1_free)
      v1_r <= in_tvalid;
    if (accept) begin
      dry1_r  <= in_sample;
      gain1_r <= (in_gain > alcr_pkg::UNITY_GAIN) ? alcr_pkg::UNITY_GAIN : in_gain;
      fwd1_r  <= fwd_now;
      loop1_r <= loop_now;
    end
  end

  // stage 2: dry and wet products
  logic [SB-1:0]         wet1;
  logic [GW-1:0]         dry_coef;
  logic signed [SB:0]    dry_s, wet_s;
  logic signed [GW:0]    gdry_s, gwet_s;

  always_comb begin
    wet1     = (loop1_r && !fwd1_r) ? rd_data_r : dry1_r;
    dry_coef = alcr_pkg::UNITY_GAIN - gain1_r;
    dry_s    = $signed({dry1_r[SB-1], dry1_r});
    wet_s    = $signed({wet1[SB-1], wet1});
    gdry_s   = $signed({1'b0, dry_coef});
    gwet_s   = $signed({1'b0, gain1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      v2_r <= 1'b0;
    else if (s2_free)
      v2_r <= v1_r;
    if (adv1) begin
      pdry2_r <= PRW'(dry_s * gdry_s);
      pwet2_r <= PRW'(wet_s * gwet_s);
      loop2_r <= loop1_r;
    end
  end

  // stage 3: sum, round half up, saturate
  logic signed [SW-1:0] sum_c;
  logic signed [RW-1:0] res_c;
  logic [SB-1:0]        sat_c;

  always_comb begin
    sum_c = SW'(pdry2_r) + SW'(pwet2_r) + $signed(alcr_pkg::ROUND_HALF);
    res_c = RW'(sum_c >>> alcr_pkg::FRAC_BITS);
    if (res_c > SAT_MAX)
      sat_c = SAT_MAX[SB-1:0];
    else if (res_c < SAT_MIN)
      sat_c = SAT_MIN[SB-1:0];
    else
      sat_c = res_c[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (s3_free)
      out_valid_r <= v2_r;
    if (adv2) begin
      out_data_r <= sat_c;
      out_loop_r <= loop2_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_loop_r;

endmodule
`default_nettype wire
